FILE: src/csvfs_pkg.sv
package csvfs_pkg;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;

  localparam logic [0:0] ACTION_CHAR = 1'b0;
  localparam logic [0:0] ACTION_EOL  = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // Work left for the back end after the front has classified a character.
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_SPACE,
    OP_FIELD,
    OP_LINE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } entry_t;

endpackage

FILE: src/csv_field_splitter_unit.sv
// CSV field splitter.
// Input stream: one beat per character (s_tuser = 0, s_tdata = byte) or per
// end-of-line mark (s_tuser = 1, s_tdata ignored).
// Output stream: one beat per content byte, field end or line end, with the
// kind in m_tuser and byte, withheld space count, column, row and the running
// maximum column count in m_tdata. Quote toggles and spaces give no beat.
// The delimiter register sits at APB address 0 and resets to a comma. It is
// to be written only while the stream is idle, which the block does not
// enforce; a write applies from the next beat on. Throughput is one input
// beat per cycle while the queue has room. A character is classified as it
// is accepted and written into the queue; the back end takes it from the
// queue head and loads its result into the output register.
// When m_tready is low the output register holds its beat, the back end stops
// and the two-entry queue fills; s_tready falls when the queue is full, so no
// beat is lost. The output register still takes a new beat in the cycle its
// old one leaves, so flow continues at full rate under sustained ready.
// Synchronous reset clears quoted mode, all counters, the queue and the
// output valid, and sets the delimiter back to a comma.
module csv_field_splitter_unit #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: char_byte [7:0]
  input  logic [7:0]                    s_tdata,
  // s_tuser: action [0]
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: out_byte, spaces_before, column_index, row_index, max_columns, zero fill
  output logic [(((16 + $clog2(MAX_COLUMNS) + $clog2(MAX_ROWS)
                 + $clog2(MAX_COLUMNS + 1)) + 7) / 8) * 8 - 1:0] m_tdata,
  // m_tuser: kind [1:0]
  output logic [1:0]                    m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int MW = $clog2(MAX_COLUMNS + 1);
  localparam int FW = 16 + CW + RW + MW;
  localparam int DW = ((FW + 7) / 8) * 8;

  logic [7:0]        delimiter;
  logic              q_full;
  logic              q_push;
  csvfs_pkg::entry_t q_push_entry;
  logic              q_pop;
  logic              q_not_empty;
  csvfs_pkg::entry_t q_head;

  logic [7:0]    res_byte;
  logic [7:0]    res_spaces;
  logic [CW-1:0] res_column;
  logic [RW-1:0] res_row;
  logic [MW-1:0] res_max;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, delimiter} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= csvfs_pkg::COMMA_CHAR;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      delimiter <= pwdata[7:0];
    end
  end

  csvfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .delimiter (delimiter),
    .in_valid  (s_tvalid),
    .in_action (s_tuser[0]),
    .in_char   (s_tdata),
    .in_ready  (s_tready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_push_entry)
  );

  csvfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head_entry (q_head)
  );

  csvfs_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_entry    (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_byte   (res_byte),
    .out_spaces (res_spaces),
    .out_column (res_column),
    .out_row    (res_row),
    .out_max    (res_max)
  );

  assign m_tdata = DW'({res_max, res_row, res_column, res_spaces, res_byte});

endmodule

FILE: src/csvfs_front.sv
module csvfs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          delimiter,
  input  logic                in_valid,
  input  logic                in_action,
  input  logic [7:0]          in_char,
  output logic                in_ready,
  input  logic                q_full,
  output logic                q_push,
  output csvfs_pkg::entry_t   q_entry
);

  logic in_quotes;
  logic in_quotes_next;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    in_quotes_next = in_quotes;
    q_push         = 1'b0;
    q_entry.op     = csvfs_pkg::OP_BYTE;
    q_entry.data   = in_char;
    if (accept) begin
      priority if (in_action == csvfs_pkg::ACTION_EOL) begin
        q_push         = 1'b1;
        q_entry.op     = csvfs_pkg::OP_LINE;
        in_quotes_next = 1'b0;
      end else if (in_char == csvfs_pkg::QUOTE_CHAR && delimiter != csvfs_pkg::QUOTE_CHAR) begin
        // A toggling quote is consumed here and never reaches the back end.
        in_quotes_next = !in_quotes;
      end else if (in_char == delimiter && !in_quotes) begin
        q_push     = 1'b1;
        q_entry.op = csvfs_pkg::OP_FIELD;
      end else if (in_char == csvfs_pkg::SPACE_CHAR) begin
        q_push     = 1'b1;
        q_entry.op = csvfs_pkg::OP_SPACE;
      end else begin
        q_push     = 1'b1;
        q_entry.op = csvfs_pkg::OP_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes <= 1'b0;
    end else begin
      in_quotes <= in_quotes_next;
    end
  end

endmodule

FILE: src/csvfs_queue.sv
module csvfs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csvfs_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output csvfs_pkg::entry_t head_entry
);

  localparam int PW = (csvfs_pkg::QUEUE_DEPTH > 1) ? $clog2(csvfs_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(csvfs_pkg::QUEUE_DEPTH + 1);

  csvfs_pkg::entry_t slots [csvfs_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(csvfs_pkg::QUEUE_DEPTH));
  assign not_empty  = (count != '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && not_empty;
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(csvfs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(csvfs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/csvfs_back.sv
module csvfs_back #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  csvfs_pkg::entry_t                    q_entry,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_kind,
  output logic [7:0]                           out_byte,
  output logic [7:0]                           out_spaces,
  output logic [$clog2(MAX_COLUMNS)-1:0]       out_column,
  output logic [$clog2(MAX_ROWS)-1:0]          out_row,
  output logic [$clog2(MAX_COLUMNS+1)-1:0]     out_max
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int MW = $clog2(MAX_COLUMNS + 1);

  logic          field_started;
  logic [7:0]    pending_spaces;
  logic [CW-1:0] column_counter;
  logic [RW-1:0] row_counter;
  logic [MW-1:0] max_column_reg;

  logic [MW-1:0] line_count;
  logic [MW-1:0] max_next;

  assign q_pop      = q_valid && (!out_valid || out_ready);
  // The column counter never passes MAX_COLUMNS-1, so the count needs no clamp.
  assign line_count = MW'(column_counter) + 1'b1;
  assign max_next   = (line_count > max_column_reg) ? line_count : max_column_reg;

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.op != csvfs_pkg::OP_SPACE) begin
      out_column <= column_counter;
      out_row    <= row_counter;
      out_max    <= max_column_reg;
      out_byte   <= 8'd0;
      out_spaces <= 8'd0;
      unique case (q_entry.op)
        csvfs_pkg::OP_LINE: begin
          out_kind <= csvfs_pkg::KIND_LINE;
          out_max  <= max_next;
        end
        csvfs_pkg::OP_FIELD: begin
          out_kind <= csvfs_pkg::KIND_FIELD;
        end
        default: begin
          out_kind   <= csvfs_pkg::KIND_BYTE;
          out_byte   <= q_entry.data;
          out_spaces <= pending_spaces;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      field_started  <= 1'b0;
      pending_spaces <= 8'd0;
      column_counter <= '0;
      row_counter    <= '0;
      max_column_reg <= '0;
    end else begin
      if (q_pop && q_entry.op != csvfs_pkg::OP_SPACE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        unique case (q_entry.op)
          csvfs_pkg::OP_LINE: begin
            max_column_reg <= max_next;
            if (row_counter != RW'(MAX_ROWS - 1)) begin
              row_counter <= row_counter + 1'b1;
            end
            column_counter <= '0;
            field_started  <= 1'b0;
            pending_spaces <= 8'd0;
          end
          csvfs_pkg::OP_FIELD: begin
            if (column_counter != CW'(MAX_COLUMNS - 1)) begin
              column_counter <= column_counter + 1'b1;
            end
            field_started  <= 1'b0;
            pending_spaces <= 8'd0;
          end
          csvfs_pkg::OP_SPACE: begin
            // Leading spaces vanish; interior ones are counted until a byte claims them.
            if (field_started && pending_spaces != 8'hFF) begin
              pending_spaces <= pending_spaces + 1'b1;
            end
          end
          default: begin
            field_started  <= 1'b1;
            pending_spaces <= 8'd0;
          end
        endcase
      end
    end
  end

endmodule

FILE: test/csv_field_splitter_unit_test.sv
`timescale 1ns / 1ps

module csv_field_splitter_unit_test;

  localparam logic [2:0] DELIM_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  spaces;
    logic [9:0]  col;
    logic [15:0] row;
    logic [10:0] maxc;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [0:0]  s_tuser = csvfs_pkg::ACTION_CHAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted splitter state.
  logic [7:0]  delim = csvfs_pkg::COMMA_CHAR;
  logic        quoted = 1'b0;
  logic        started = 1'b0;
  logic [7:0]  held = 8'd0;
  logic [9:0]  col_cnt = 10'd0;
  logic [15:0] row_cnt = 16'd0;
  logic [10:0] max_cols = 11'd0;

  token_t tokens_due[$];
  int     mismatches = 0;
  bit     steady = 1'b0;
  int     hold_token = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     stall_cycles = 0;

  csv_field_splitter_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void add_token(input token_t t);
    tokens_due.insert(tokens_due.size(), t);
  endfunction

  function automatic void split_char(logic [0:0] act, logic [7:0] ch);
    token_t t;
    t = '{kind: csvfs_pkg::KIND_BYTE, data: 8'd0, spaces: 8'd0, col: col_cnt,
          row: row_cnt, maxc: max_cols};
    if (act == csvfs_pkg::ACTION_EOL) begin
      if ({1'b0, col_cnt} + 11'd1 > max_cols) max_cols = {1'b0, col_cnt} + 11'd1;
      t.kind = csvfs_pkg::KIND_LINE;
      t.maxc = max_cols;
      add_token(t);
      if (row_cnt != 16'hFFFF) row_cnt++;
      col_cnt = 10'd0;
      quoted = 1'b0;
      started = 1'b0;
      held = 8'd0;
    end else if (ch == csvfs_pkg::QUOTE_CHAR && delim != csvfs_pkg::QUOTE_CHAR) begin
      quoted = !quoted;
    end else if (ch == delim && !quoted) begin
      t.kind = csvfs_pkg::KIND_FIELD;
      add_token(t);
      if (col_cnt != 10'h3FF) col_cnt++;
      started = 1'b0;
      held = 8'd0;
    end else if (ch == csvfs_pkg::SPACE_CHAR) begin
      if (started && held != 8'hFF) held++;
    end else begin
      t.data = ch;
      t.spaces = held;
      add_token(t);
      started = 1'b1;
      held = 8'd0;
    end
  endfunction

  task automatic send_item(input logic [0:0] act, input logic [7:0] ch);
    while (!steady && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= ch;
    do @(posedge clk); while (!s_tready);
    split_char(act, ch);
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_item(csvfs_pkg::ACTION_CHAR, ch);
  endtask

  // The byte that travels with a line end is ignored, so it is random.
  task automatic send_eol();
    send_item(csvfs_pkg::ACTION_EOL, 8'($urandom_range(255)));
  endtask

  // Waits for every expected beat, then lets work that gives no beat settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
    logic [31:0] want;
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == DELIM_ADDR) delim = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // Only the delimiter exists; the spare address used here reads as zero.
    want = (addr == DELIM_ADDR) ? {24'd0, delim} : 32'd0;
    if (prdata != want) begin
      mismatches++;
      $error("prdata: expected %0d, got %0d", want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_text(input string text);
    foreach (text[i]) send_char(text[i]);
  endtask

  task automatic test_spaces_and_fields();
    send_text("  a  b , c ");
    send_eol();
    send_text("x,,");
    send_eol();
    drain();
  endtask

  task automatic test_quotes();
    send_text("\"p, q\",r");
    send_eol();
    // A quote left open is closed by the line end.
    send_text("\"s,");
    send_eol();
    send_text("t,");
    send_eol();
    drain();
  endtask

  task automatic test_byte_extremes();
    send_char(8'h00);
    send_char(8'hFF);
    send_item(csvfs_pkg::ACTION_EOL, 8'hFF);
    send_item(csvfs_pkg::ACTION_EOL, 8'h00);
    write_reg(DELIM_ADDR, 8'h00);
    send_char(8'hFF);
    send_char(8'h00);
    send_eol();
    write_reg(DELIM_ADDR, 8'hFF);
    send_char(8'h00);
    send_char(8'hFF);
    send_eol();
    write_reg(DELIM_ADDR, csvfs_pkg::COMMA_CHAR);
  endtask

  task automatic test_quote_delimiter();
    // Quoted mode entered under a comma keeps the quote as content afterwards.
    send_char(csvfs_pkg::QUOTE_CHAR);
    write_reg(DELIM_ADDR, csvfs_pkg::QUOTE_CHAR);
    send_char("q");
    send_char(csvfs_pkg::QUOTE_CHAR);
    send_eol();
    send_char(csvfs_pkg::QUOTE_CHAR);
    send_text("r,");
    send_eol();
    write_reg(DELIM_ADDR, csvfs_pkg::COMMA_CHAR);
  endtask

  task automatic test_space_delimiter();
    write_reg(DELIM_ADDR, csvfs_pkg::SPACE_CHAR);
    send_text("a b\"  c \" d");
    send_eol();
    write_reg(DELIM_ADDR, csvfs_pkg::COMMA_CHAR);
  endtask

  task automatic test_spare_address();
    write_reg(SPARE_ADDR, 8'h3B);
    send_text("a;b,c");
    send_eol();
    drain();
  endtask

  task automatic test_space_saturation();
    send_char("a");
    repeat (300) send_char(csvfs_pkg::SPACE_CHAR);
    send_char("b");
    repeat (20) send_char(csvfs_pkg::SPACE_CHAR);
    send_char(delim);
    send_eol();
    drain();
  endtask

  task automatic test_backpressure();
    hold_token++;
    steady = 1'b1;
    for (int i = 0; i < 30; i++) send_char(8'($urandom_range(8'h30, 8'h7A)));
    send_eol();
    steady = 1'b0;
    drain();
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 55) return csvfs_pkg::SPACE_CHAR;
    if (r < 67) return delim;
    if (r < 75) return csvfs_pkg::QUOTE_CHAR;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_phase(input logic [7:0] sep, input int quota, input bit no_gaps);
    int sent;
    int len;
    sent = 0;
    write_reg(DELIM_ADDR, sep);
    steady = no_gaps;
    while (sent < quota) begin
      len = $urandom_range(16);
      repeat (len) send_char(pick_char());
      send_eol();
      sent += len + 1;
    end
    steady = 1'b0;
    drain();
  endtask

  task automatic test_random();
    random_phase(csvfs_pkg::COMMA_CHAR, 60, 1'b0);
    random_phase(8'h09, 55, 1'b0);
    random_phase(8'h3B, 150, 1'b1);
    random_phase(8'h00, 55, 1'b0);
    random_phase(8'hFF, 55, 1'b0);
    random_phase(csvfs_pkg::QUOTE_CHAR, 55, 1'b0);
    random_phase(csvfs_pkg::SPACE_CHAR, 55, 1'b0);
    write_reg(DELIM_ADDR, csvfs_pkg::COMMA_CHAR);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_spaces_and_fields();
    test_quotes();
    test_byte_extremes();
    test_quote_delimiter();
    test_space_delimiter();
    test_spare_address();
    test_space_saturation();
    test_backpressure();
    test_random();
    repeat (8) @(posedge clk);
    if (tokens_due.size() != 0) begin
      mismatches++;
      $error("%0d expected beats never arrived", tokens_due.size());
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 19);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    token_t t;
    if (!rst && m_tvalid && m_tready) begin
      if (tokens_due.size() == 0) begin
        mismatches++;
        $error("unexpected output beat, kind %0d", m_tuser);
      end else begin
        t = tokens_due.pop_front();
        check_field("kind", t.kind, m_tuser);
        check_field("out_byte", t.data, m_tdata[7:0]);
        check_field("spaces_before", t.spaces, m_tdata[15:8]);
        check_field("column_index", t.col, m_tdata[25:16]);
        check_field("row_index", t.row, m_tdata[41:26]);
        check_field("max_columns", t.maxc, m_tdata[52:42]);
      end
    end
  end

  // Ends the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
